// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console cell writer
// Request and result payloads, command codes, register indexes, character
// codes and register reset values.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // field widths of the request and result payloads
   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int ATTR_W  = 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT_CHAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCROLL    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_CELL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTRIBUTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE    = 2'd2;

   // register reset values
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
   localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;
   localparam logic [ROW_W-1:0]  ROWS_RESET = 5'd25;

   // special character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
      logic              needs_scroll;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic exec_put;
      logic exec_scroll;
      logic exec_read;
      logic scroll_step;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic scroll_last;
   } dp_status_type;

endpackage

// ----- sv/text_console_cell_writer.sv -----
// Put-char, read-cell and unused commands: result in the cycle after the request
//   is taken, busy meanwhile; no new request is taken until the result is shown.
// Scroll: result after a sweep over the rows*cols cells in use, one cell moved per
//   cycle through the single read and single write port of the screen store.
// Reset: a clearing pass over all MAX_COLS*MAX_ROWS cells (2000 by default) zeroes
//   the screen store with busy high; register writes are taken meanwhile.
// ----------------------------------------------------------------------------
// text_console_cell_writer: text-mode console engine
// Keeps a cursor and a screen store of attribute/character cells; answers
// put-char, scroll, read-cell and unused-code requests with one result each.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_start,
   output logic                           busy,
   input  tcw_pkg::req_type               req_payload,
   output logic                           rsp_strobe,
   output tcw_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tcw_pkg::ctl_cmd_type   cmd;
   tcw_pkg::dp_status_type status;

   // sequencing
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_command(req_payload.command),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // cursor, registers and screen store
   tcw_datapath #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS),
      .TAB_STOP(TAB_STOP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

// ----- sv/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: generic single write, single read port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine of the console cell writer
// Runs the clearing pass after reset, takes requests, steps the scroll
// sweep and marks the result cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   input  logic [tcw_pkg::CMD_W-1:0]   req_command,
   input  tcw_pkg::dp_status_type      status,
   output tcw_pkg::ctl_cmd_type        cmd,
   output logic                        busy,
   output logic                        rsp_strobe
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_start;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_start) begin
               state_in = (req_command == tcw_pkg::CMD_SCROLL) ? ST_SCROLL : ST_RESP;
            end
         end
         ST_SCROLL: begin
            if (status.scroll_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.accept      = accept;
      cmd.clear_step  = (state_ff == ST_CLEAR);
      cmd.exec_put    = accept && (req_command == tcw_pkg::CMD_PUT_CHAR);
      cmd.exec_scroll = accept && (req_command == tcw_pkg::CMD_SCROLL);
      cmd.exec_read   = accept && (req_command == tcw_pkg::CMD_READ_CELL);
      cmd.scroll_step = (state_ff == ST_SCROLL);
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule

// ----- sv/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, registers and screen store of the console
// Applies put-char to the cursor, writes cells, walks the screen store for
// the clearing pass and the scroll, and forms the result fields.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::ctl_cmd_type              cmd,
   output tcw_pkg::dp_status_type            status,
   input  tcw_pkg::req_type                  req_payload,
   output tcw_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int LIN_W      = (ADDR_W + 2 > 13) ? ADDR_W + 2 : 13;
   localparam int PH_W       = $clog2(TAB_STOP);
   localparam int COL_W      = tcw_pkg::COL_W;
   localparam int ROW_W      = tcw_pkg::ROW_W;
   localparam int POS_PROD_W = COL_W + ROW_W + 1;

   // configuration registers
   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic [COL_W-1:0]           cols_ff;
   logic [ROW_W-1:0]           rows_ff;

   // cursor state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PH_W-1:0]  ph_ff, ph_in;

   // sweep pointer shared by clearing pass and scroll
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              data_sel_ff;

   // effective screen size
   logic [COL_W-1:0] w;
   logic [ROW_W-1:0] h;

   // put-char datapath
   logic [ROW_W-1:0] row_a, row_b, row_nl;
   logic [COL_W-1:0] col_a;
   logic [PH_W-1:0]  ph_a;
   logic [COL_W:0]   tab_col, col_inc;
   logic [COL_W-1:0] put_col;
   logic [ROW_W-1:0] put_row;
   logic [PH_W-1:0]  put_ph;
   logic             put_char_we;
   logic [LIN_W-1:0] put_lin;

   // scroll sweep
   logic [LIN_W-1:0] total, move_end, rd_next, ptr_lin;

   // read cell
   logic index_ok;

   // memory ports
   logic                       ram_we, ram_re;
   logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   logic [POS_PROD_W-1:0] pos_full;

   // width and height limited to the screen store, zero taken as one
   always_comb begin
      if (cols_ff == '0) begin
         w = COL_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         w = COL_W'(MAX_COLS);
      end else begin
         w = cols_ff;
      end
      if (rows_ff == '0) begin
         h = ROW_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         h = ROW_W'(MAX_ROWS);
      end else begin
         h = rows_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
         cols_ff <= tcw_pkg::COLS_RESET;
         rows_ff <= tcw_pkg::ROWS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tcw_pkg::CSR_TEXT_ATTRIBUTE: attr_ff <= csr_wdata;
            tcw_pkg::CSR_COLS_IN_USE:    cols_ff <= csr_wdata[COL_W-1:0];
            tcw_pkg::CSR_ROWS_IN_USE:    rows_ff <= csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // put-char: limit row, wrap a column beyond width, then handle the code
   always_comb begin
      row_a = (row_ff > h) ? h : row_ff;
      if (col_ff >= w) begin
         col_a = '0;
         ph_a  = '0;
         row_b = (row_a < h) ? row_a + ROW_W'(1) : row_a;
      end else begin
         col_a = col_ff;
         ph_a  = ph_ff;
         row_b = row_a;
      end
      row_nl  = (row_b < h) ? row_b + ROW_W'(1) : row_b;
      tab_col = {1'b0, col_a} + (COL_W+1)'(TAB_STOP) - (COL_W+1)'(ph_a);
      col_inc = {1'b0, col_a} + (COL_W+1)'(1);
      put_lin = LIN_W'(row_b) * LIN_W'(w) + LIN_W'(col_a);

      put_col     = col_a;
      put_row     = row_b;
      put_ph      = ph_a;
      put_char_we = 1'b0;
      priority if (req_payload.char_code == tcw_pkg::CH_NEWLINE) begin
         put_col = '0;
         put_ph  = '0;
         put_row = row_nl;
      end else if (req_payload.char_code == tcw_pkg::CH_TAB) begin
         if (tab_col >= {1'b0, w}) begin
            put_col = '0;
            put_ph  = '0;
            put_row = row_nl;
         end else begin
            put_col = tab_col[COL_W-1:0];
            put_ph  = '0;
         end
      end else if (row_b < h) begin
         put_char_we = (put_lin < LIN_W'(CELL_COUNT));
         if (col_inc >= {1'b0, w}) begin
            put_col = '0;
            put_ph  = '0;
            put_row = row_nl;
         end else begin
            put_col = col_inc[COL_W-1:0];
            put_ph  = (int'(ph_a) == TAB_STOP - 1) ? '0 : ph_a + PH_W'(1);
         end
      end else begin
         // character dropped at the saturated row
         put_col = col_a;
      end
   end

   // scroll sweep bounds
   always_comb begin
      total    = LIN_W'(h) * LIN_W'(w);
      move_end = total - LIN_W'(w);
      ptr_lin  = LIN_W'(ptr_ff);
      rd_next  = ptr_lin + LIN_W'(w) + LIN_W'(1);
   end

   assign status.clear_last  = (ptr_ff == ADDR_W'(CELL_COUNT - 1));
   assign status.scroll_last = (ptr_lin == total - LIN_W'(1));

   assign index_ok = (int'(req_payload.cell_index) < CELL_COUNT);

   // memory write and read selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = '0;
      priority if (cmd.clear_step) begin
         ram_we = 1'b1;
      end else if (cmd.scroll_step) begin
         ram_we = 1'b1;
         if (ptr_lin < move_end) begin
            ram_wdata = {attr_ff, ram_rdata[tcw_pkg::CHAR_W-1:0]};
         end else begin
            ram_wdata = {attr_ff, tcw_pkg::CH_SPACE};
         end
      end else if (cmd.exec_put) begin
         ram_we    = put_char_we;
         ram_waddr = ADDR_W'(put_lin);
         ram_wdata = {attr_ff, req_payload.char_code};
      end else begin
         ram_we = 1'b0;
      end

      ram_re    = 1'b0;
      ram_raddr = ADDR_W'(req_payload.cell_index);
      priority if (cmd.exec_read) begin
         ram_re = index_ok;
      end else if (cmd.exec_scroll) begin
         ram_re    = (LIN_W'(w) < total);
         ram_raddr = ADDR_W'(w);
      end else if (cmd.scroll_step) begin
         ram_re    = (rd_next < total);
         ram_raddr = ADDR_W'(rd_next);
      end else begin
         ram_re = 1'b0;
      end
   end

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_screen_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // cursor and pointer next values
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ph_in  = ph_ff;
      ptr_in = ptr_ff;
      priority if (cmd.clear_step) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end else if (cmd.exec_put) begin
         col_in = put_col;
         row_in = put_row;
         ph_in  = put_ph;
      end else if (cmd.exec_scroll) begin
         ptr_in = '0;
      end else if (cmd.scroll_step) begin
         ptr_in = ptr_ff + ADDR_W'(1);
         if (status.scroll_last) row_in = h - ROW_W'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         ph_ff       <= '0;
         ptr_ff      <= '0;
         data_sel_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ph_ff  <= ph_in;
         ptr_ff <= ptr_in;
         if (cmd.accept) data_sel_ff <= cmd.exec_read && index_ok;
      end
   end

   // result fields from the cursor and the read cell
   assign pos_full = POS_PROD_W'(row_ff) * POS_PROD_W'(w) + POS_PROD_W'(col_ff);

   always_comb begin
      rsp_payload.cursor_col   = col_ff;
      rsp_payload.cursor_row   = row_ff;
      rsp_payload.cursor_pos   = pos_full[tcw_pkg::POS_W-1:0];
      rsp_payload.cell_data    = data_sel_ff ? ram_rdata : '0;
      rsp_payload.needs_scroll = (row_ff >= h);
   end

endmodule

// ----- sv/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the console cell writer
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_start,
   input logic             busy,
   input tcw_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input tcw_pkg::rsp_type rsp_payload
);

   // a taken request makes the block busy
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy |=> busy)
      else $error("busy low after a request was taken");

   // a result is only shown while busy
   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   // results never come in consecutive cycles
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result repeated in the next cycle");

   // put-char answers in the next cycle with empty cell data
   a_put_char_result: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy && (req_payload.command == tcw_pkg::CMD_PUT_CHAR)
      |=> rsp_strobe && (rsp_payload.cell_data == 16'h0000))
      else $error("put-char result missing or carries cell data");

endmodule

bind text_console_cell_writer tcw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_start  (req_start),
   .busy       (busy),
   .req_payload(req_payload),
   .rsp_strobe (rsp_strobe),
   .rsp_payload(rsp_payload)
);

// ----- tb/tb_text_console_cell_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer: self-checking bench for the console engine
// A short table of directed requests and register writes, then phases of
// random requests under varied screen sizes and attributes. Every result is
// checked field by field against table values or a copy of cursor and screen.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;

   localparam int CONSOLE_COLS   = 80;
   localparam int CONSOLE_ROWS   = 25;
   localparam int TAB_WIDTH      = 8;
   localparam int CELL_COUNT     = CONSOLE_COLS * CONSOLE_ROWS;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 100;
   localparam int QUIET_PHASE    = 3;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int STALL_LIMIT    = 10000;

   // codes the package leaves unnamed
   localparam logic [tcw_pkg::CMD_W-1:0]     CMD_UNUSED      = 2'd3;
   localparam logic [tcw_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   // screen sizes per random phase; the last phase picks its own
   localparam int PHASE_COLS [RANDOM_PHASES] = '{8, 1, 80, 16, 0, 127, 5, 40, 80, 0};
   localparam int PHASE_ROWS [RANDOM_PHASES] = '{4, 6, 25, 3, 0, 31, 1, 2, 12, 0};

   typedef enum logic {STEP_REQUEST, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type                     kind;
      tcw_pkg::req_type                  req;
      logic [tcw_pkg::CSR_IDX_W-1:0]     csr_idx;
      logic [tcw_pkg::CSR_DATA_W-1:0]    csr_val;
      bit                                typed;
      tcw_pkg::rsp_type                  rsp;
   } directed_step_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_start;
   logic                           busy;
   tcw_pkg::req_type               req_payload;
   logic                           rsp_strobe;
   tcw_pkg::rsp_type               rsp_payload;
   logic                           csr_write_en;
   logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata;

   // behavioural copy of the registers, cursor and screen store
   logic [tcw_pkg::ATTR_W-1:0]     shadow_attr;
   logic [tcw_pkg::COL_W-1:0]      shadow_cols;
   logic [tcw_pkg::ROW_W-1:0]      shadow_rows;
   int                             cur_col;
   int                             cur_row;
   logic [tcw_pkg::CELL_W-1:0]     screen_mem [CELL_COUNT];

   tcw_pkg::rsp_type               cursor_reports_q [$];
   directed_step_type              directed_steps [$];
   bit                             sender_idles;
   int                             mismatch_count = 0;
   int                             quiet_cycles = 0;

   text_console_cell_writer #(
      .MAX_COLS (CONSOLE_COLS),
      .MAX_ROWS (CONSOLE_ROWS),
      .TAB_STOP (TAB_WIDTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_start    (req_start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // effective screen size, limited to the store's dimensions
   function automatic int screen_width();
      if (shadow_cols == 0) return 1;
      if (int'(shadow_cols) > CONSOLE_COLS) return CONSOLE_COLS;
      return int'(shadow_cols);
   endfunction

   function automatic int screen_height();
      if (shadow_rows == 0) return 1;
      if (int'(shadow_rows) > CONSOLE_ROWS) return CONSOLE_ROWS;
      return int'(shadow_rows);
   endfunction

   // column 0 of the next row, the row saturating at the height
   function automatic void advance_line(int h);
      cur_col = 0;
      if (cur_row < h) cur_row++;
   endfunction

   // applies one command to the copy and returns the cursor report it gives
   function automatic tcw_pkg::rsp_type apply_console_command(tcw_pkg::req_type r);
      tcw_pkg::rsp_type           o;
      int                         w;
      int                         h;
      int                         c;
      int                         idx;
      int                         pos;
      logic [tcw_pkg::CELL_W-1:0] data;
      w    = screen_width();
      h    = screen_height();
      data = '0;
      unique case (r.command)
         tcw_pkg::CMD_PUT_CHAR: begin
            if (cur_row > h) cur_row = h;
            if (cur_col >= w) advance_line(h);
            if (r.char_code == tcw_pkg::CH_NEWLINE) begin
               advance_line(h);
            end else if (r.char_code == tcw_pkg::CH_TAB) begin
               c = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
               if (c >= w) advance_line(h);
               else cur_col = c;
            end else if (cur_row < h) begin
               idx = cur_row * w + cur_col;
               if (idx < CELL_COUNT) screen_mem[idx] = {shadow_attr, r.char_code};
               cur_col++;
               if (cur_col >= w) advance_line(h);
            end
         end
         tcw_pkg::CMD_SCROLL: begin
            // every row moves up and takes the current attribute
            for (int y = 1; y < h; y++)
               for (int x = 0; x < w; x++)
                  screen_mem[(y - 1) * w + x] =
                     {shadow_attr, screen_mem[y * w + x][tcw_pkg::CHAR_W-1:0]};
            for (int x = 0; x < w; x++)
               screen_mem[(h - 1) * w + x] = {shadow_attr, tcw_pkg::CH_SPACE};
            cur_row = h - 1;
         end
         tcw_pkg::CMD_READ_CELL: begin
            if (r.cell_index < CELL_COUNT) data = screen_mem[r.cell_index];
         end
         default: ;
      endcase
      pos            = cur_row * w + cur_col;
      o.cursor_col   = cur_col[tcw_pkg::COL_W-1:0];
      o.cursor_row   = cur_row[tcw_pkg::ROW_W-1:0];
      o.cursor_pos   = pos[tcw_pkg::POS_W-1:0];
      o.cell_data    = data;
      o.needs_scroll = (cur_row >= h);
      return o;
   endfunction

   // directed table entries
   function automatic void table_request(logic [tcw_pkg::CMD_W-1:0] cmd,
                                         logic [tcw_pkg::CHAR_W-1:0] ch,
                                         logic [tcw_pkg::INDEX_W-1:0] idx);
      directed_step_type s;
      s.kind    = STEP_REQUEST;
      s.req     = '{command: cmd, char_code: ch, cell_index: idx};
      s.csr_idx = '0;
      s.csr_val = '0;
      s.typed   = 1'b0;
      s.rsp     = '0;
      directed_steps.push_back(s);
   endfunction

   function automatic void table_checked(logic [tcw_pkg::CMD_W-1:0] cmd,
                                         logic [tcw_pkg::CHAR_W-1:0] ch,
                                         logic [tcw_pkg::INDEX_W-1:0] idx,
                                         logic [tcw_pkg::COL_W-1:0] col,
                                         logic [tcw_pkg::ROW_W-1:0] row,
                                         logic [tcw_pkg::POS_W-1:0] pos,
                                         logic [tcw_pkg::CELL_W-1:0] data,
                                         logic scroll_flag);
      directed_step_type s;
      s.kind             = STEP_REQUEST;
      s.req              = '{command: cmd, char_code: ch, cell_index: idx};
      s.csr_idx          = '0;
      s.csr_val          = '0;
      s.typed            = 1'b1;
      s.rsp.cursor_col   = col;
      s.rsp.cursor_row   = row;
      s.rsp.cursor_pos   = pos;
      s.rsp.cell_data    = data;
      s.rsp.needs_scroll = scroll_flag;
      directed_steps.push_back(s);
   endfunction

   function automatic void table_csr(logic [tcw_pkg::CSR_IDX_W-1:0] idx,
                                     logic [tcw_pkg::CSR_DATA_W-1:0] val);
      directed_step_type s;
      s.kind    = STEP_CSR;
      s.req     = '0;
      s.csr_idx = idx;
      s.csr_val = val;
      s.typed   = 1'b0;
      s.rsp     = '0;
      directed_steps.push_back(s);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t ns", what, got, want, $time);
      mismatch_count++;
   endtask

   // one request: optional idle gap, then held until taken
   task automatic issue_request(input tcw_pkg::req_type r, input bit typed,
                                input tcw_pkg::rsp_type typed_rsp);
      tcw_pkg::rsp_type predicted;
      if (sender_idles) begin
         while ($urandom_range(99) < 24) begin
            @(negedge clock);
            req_start <= 1'b0;
         end
      end
      @(negedge clock);
      req_start   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_console_command(r);
      cursor_reports_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // stop sending and wait until every result is back
   task automatic drain_reports();
      @(negedge clock);
      req_start <= 1'b0;
      while (cursor_reports_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tcw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tcw_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      unique case (idx)
         tcw_pkg::CSR_TEXT_ATTRIBUTE: shadow_attr = val;
         tcw_pkg::CSR_COLS_IN_USE:    shadow_cols = val[tcw_pkg::COL_W-1:0];
         tcw_pkg::CSR_ROWS_IN_USE:    shadow_rows = val[tcw_pkg::ROW_W-1:0];
         default: ;
      endcase
   endtask

   // result checking against the oldest pending report
   always @(posedge clock) begin : check_results
      tcw_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (cursor_reports_q.size() == 0) begin
            report_mismatch("result with no request pending", 1, 0);
         end else begin
            want = cursor_reports_q.pop_front();
            if (rsp_payload.cursor_col !== want.cursor_col)
               report_mismatch("cursor_col", int'(rsp_payload.cursor_col),
                               int'(want.cursor_col));
            if (rsp_payload.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", int'(rsp_payload.cursor_row),
                               int'(want.cursor_row));
            if (rsp_payload.cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", int'(rsp_payload.cursor_pos),
                               int'(want.cursor_pos));
            if (rsp_payload.cell_data !== want.cell_data)
               report_mismatch("cell_data", int'(rsp_payload.cell_data),
                               int'(want.cell_data));
            if (rsp_payload.needs_scroll !== want.needs_scroll)
               report_mismatch("needs_scroll", int'(rsp_payload.needs_scroll),
                               int'(want.needs_scroll));
         end
      end
   end

   // watchdog on cycles with no request taken and no result
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tcw_pkg::req_type r;
      int               area;
      int               pick;
      int               sel;
      logic [31:0]      rnd;

      reset        = 1'b1;
      req_start    = 1'b0;
      req_payload  = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      shadow_attr  = tcw_pkg::ATTR_RESET;
      shadow_cols  = tcw_pkg::COLS_RESET;
      shadow_rows  = tcw_pkg::ROWS_RESET;
      cur_col      = 0;
      cur_row      = 0;
      sender_idles = 1'b1;
      foreach (screen_mem[i]) screen_mem[i] = '0;

      // cleared store, first character, tab and newline at full size
      table_checked(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd0,
                    7'd0, 5'd0, 11'd0, 16'h0000, 1'b0);
      table_checked(tcw_pkg::CMD_READ_CELL, 8'hFF, 11'h7FF,
                    7'd0, 5'd0, 11'd0, 16'h0000, 1'b0);
      table_checked(tcw_pkg::CMD_PUT_CHAR, 8'h41, 11'd0,
                    7'd1, 5'd0, 11'd1, 16'h0000, 1'b0);
      table_checked(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd0,
                    7'd1, 5'd0, 11'd1, 16'h0741, 1'b0);
      table_checked(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 11'd0,
                    7'd8, 5'd0, 11'd8, 16'h0000, 1'b0);
      table_checked(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 11'd0,
                    7'd0, 5'd1, 11'd80, 16'h0000, 1'b0);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'hFF, 11'd0);
      table_request(CMD_UNUSED, 8'hFF, 11'h7FF);
      table_request(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd80);
      table_request(tcw_pkg::CMD_SCROLL, 8'h00, 11'd0);
      table_request(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd0);
      // row saturation: dropped character, tab and newline at the height
      table_request(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 11'd0);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'h58, 11'd0);
      table_request(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 11'd0);
      table_request(tcw_pkg::CMD_SCROLL, 8'h00, 11'd1999);
      table_request(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 11'd0);
      // column beyond a lowered width, row beyond a lowered height
      table_csr(tcw_pkg::CSR_COLS_IN_USE, 8'd8);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'h62, 11'd0);
      table_csr(tcw_pkg::CSR_ROWS_IN_USE, 8'd3);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'h63, 11'd0);
      table_request(tcw_pkg::CMD_SCROLL, 8'h00, 11'd0);
      // tab reaching the width wraps
      table_request(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 11'd0);
      // zero width and height act as one cell
      table_csr(tcw_pkg::CSR_TEXT_ATTRIBUTE, 8'hFF);
      table_csr(tcw_pkg::CSR_COLS_IN_USE, 8'd0);
      table_csr(tcw_pkg::CSR_ROWS_IN_USE, 8'd0);
      table_request(tcw_pkg::CMD_SCROLL, 8'h00, 11'd0);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'h65, 11'd0);
      table_request(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd0);
      // oversized settings clamp to the store
      table_csr(CSR_SPARE_INDEX, 8'hFF);
      table_csr(tcw_pkg::CSR_COLS_IN_USE, 8'd127);
      table_csr(tcw_pkg::CSR_ROWS_IN_USE, 8'd31);
      table_csr(tcw_pkg::CSR_TEXT_ATTRIBUTE, 8'h00);
      table_request(tcw_pkg::CMD_PUT_CHAR, 8'hAA, 11'd0);
      table_request(tcw_pkg::CMD_READ_CELL, 8'h00, 11'd2000);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            drain_reports();
            write_csr(directed_steps[i].csr_idx, directed_steps[i].csr_val);
         end else begin
            issue_request(directed_steps[i].req, directed_steps[i].typed,
                          directed_steps[i].rsp);
         end
      end

      // random phases, each under its own screen setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_reports();
         rnd = $urandom_range(255);
         write_csr(tcw_pkg::CSR_TEXT_ATTRIBUTE, rnd[tcw_pkg::CSR_DATA_W-1:0]);
         if (phase == RANDOM_PHASES - 1) rnd = $urandom_range(127);
         else rnd = PHASE_COLS[phase];
         write_csr(tcw_pkg::CSR_COLS_IN_USE, rnd[tcw_pkg::CSR_DATA_W-1:0]);
         if (phase == RANDOM_PHASES - 1) rnd = $urandom_range(31);
         else rnd = PHASE_ROWS[phase];
         write_csr(tcw_pkg::CSR_ROWS_IN_USE, rnd[tcw_pkg::CSR_DATA_W-1:0]);
         sender_idles = (phase != QUIET_PHASE);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            area = screen_width() * screen_height();
            r.command    = tcw_pkg::CMD_PUT_CHAR;
            rnd          = $urandom_range(255);
            r.char_code  = rnd[tcw_pkg::CHAR_W-1:0];
            rnd          = $urandom_range(2047);
            r.cell_index = rnd[tcw_pkg::INDEX_W-1:0];
            pick = $urandom_range(99);
            if (pick < 58) begin
               sel = $urandom_range(99);
               if (sel < 10) r.char_code = tcw_pkg::CH_NEWLINE;
               else if (sel < 20) r.char_code = tcw_pkg::CH_TAB;
               else if (sel < 25) r.char_code = tcw_pkg::CH_SPACE;
            end else if (pick < 65) begin
               r.command = tcw_pkg::CMD_SCROLL;
            end else if (pick < 95) begin
               // mostly cells on the visible screen, sometimes anywhere
               r.command = tcw_pkg::CMD_READ_CELL;
               if ($urandom_range(3) != 0) begin
                  rnd          = $urandom_range(area - 1);
                  r.cell_index = rnd[tcw_pkg::INDEX_W-1:0];
               end
            end else begin
               r.command = CMD_UNUSED;
            end
            issue_request(r, 1'b0, '0);
            if ($urandom_range(199) == 0) drain_reports();
         end
      end

      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
